FILE: rtl/core/llp_pkg.sv
// ----------------------------------------------------------------------------
// llp_pkg: shared types and constants of the LL(1) parse engine
// Sizes of the stores, payload structs, command and result codes.
// ----------------------------------------------------------------------------
package llp_pkg;

  localparam int STACK_DEPTH     = 32;
  localparam int PRODUCTIONS     = 64;
  localparam int RHS_MAX         = 16;
  localparam int TERMINALS       = 32;
  localparam int NONTERMINALS    = 32;
  localparam int EXPANSION_LIMIT = 63;

  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int OVF_W     = SP_W + 1;
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int TBL_DEPTH = NONTERMINALS * TERMINALS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CLR_W     = TBL_AW + 1;
  localparam int RHS_DEPTH = PRODUCTIONS * RHS_MAX;
  localparam int RHS_AW    = $clog2(RHS_DEPTH);
  localparam int PROD_AW   = $clog2(PRODUCTIONS);
  localparam int EXP_W     = 6;
  localparam int CNT_W     = 7;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_END_MARKER = 2'd0;
  localparam logic [1:0] CFG_TERM_COUNT = 2'd1;
  localparam logic [1:0] CFG_NONT_COUNT = 2'd2;

  // Input kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_TABLE = 3'd1;
  localparam logic [2:0] KIND_SYM   = 3'd2;
  localparam logic [2:0] KIND_LEN   = 3'd3;
  localparam logic [2:0] KIND_TOKEN = 3'd4;

  // Result actions
  localparam logic [1:0] ACT_MATCH  = 2'd0;
  localparam logic [1:0] ACT_EXPAND = 2'd1;
  localparam logic [1:0] ACT_ACCEPT = 2'd2;
  localparam logic [1:0] ACT_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_BAD_TOK  = 3'd2;
  localparam logic [2:0] ERR_NO_RULE  = 3'd3;
  localparam logic [2:0] ERR_BAD_SYM  = 3'd4;
  localparam logic [2:0] ERR_EMPTY    = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW = 3'd6;
  localparam logic [2:0] ERR_LIMIT    = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] row_nonterminal;
    logic [4:0] token;
    logic [5:0] production;
    logic       entry_valid;
    logic [3:0] position;
    logic [5:0] rhs_symbol;
    logic [4:0] rhs_length;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] stack_symbol;
    logic [5:0] used_production;
    logic [2:0] error_code;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_TABLE = 3'd1,
    OP_SYM   = 3'd2,
    OP_LEN   = 3'd3,
    OP_TOKEN = 3'd4
  } op_t;

  typedef struct packed {
    op_t   op;
    item_t f;
  } cmd_t;

  // Status of the back end seen by the front end and the top level
  typedef struct packed {
    logic            clearing;
    logic            running;
    logic [SP_W-1:0] sp;
  } status_t;

endpackage

FILE: rtl/core/llp_front.sv
// ----------------------------------------------------------------------------
// llp_front: item intake
// Accepts items, drops unknown kinds, decodes the rest into commands and
// queues them for the back end.
// ----------------------------------------------------------------------------
module llp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  llp_pkg::item_t  item,
  input  llp_pkg::status_t st,
  output logic            cmd_valid,
  output llp_pkg::cmd_t   cmd,
  input  logic            cmd_pop
);
  import llp_pkg::*;

  cmd_t       q [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       take;
  logic       keep;
  op_t        op;

  // Classify the incoming beat
  always_comb begin
    keep = 1'b1;
    op   = OP_START;
    case (item.kind)
      KIND_START: op = OP_START;
      KIND_TABLE: op = OP_TABLE;
      KIND_SYM:   op = OP_SYM;
      KIND_LEN:   op = OP_LEN;
      KIND_TOKEN: op = OP_TOKEN;
      default:    keep = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2) || st.clearing;
  assign take      = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[head];

  // Store decoded commands
  always_ff @(posedge clk) begin
    if (take && keep) begin
      q[tail] <= '{op: op, f: item};
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (take && keep) tail <= ~tail;
      if (cmd_pop)      head <= ~head;
      count <= count + {1'b0, take && keep} - {1'b0, cmd_pop};
    end
  end

endmodule

FILE: rtl/core/llp_rq.sv
// ----------------------------------------------------------------------------
// llp_rq: result queue
// Four-entry queue between the parse sequencer and the result port.
// ----------------------------------------------------------------------------
module llp_rq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  llp_pkg::result_t  wdata,
  output logic              rq_full,
  output logic              empty,
  input  logic              pop,
  output llp_pkg::result_t  result
);
  import llp_pkg::*;

  result_t    q [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       rd;

  assign rq_full = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign rd      = pop && !empty;
  assign result  = q[head];

  // Store results
  always_ff @(posedge clk) begin
    if (wr) begin
      q[tail] <= wdata;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) tail <= tail + 2'd1;
      if (rd) head <= head + 2'd1;
      count <= count + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

FILE: rtl/core/llp_back.sv
// ----------------------------------------------------------------------------
// llp_back: parse sequencer
// Owns the registers, the prediction table, the production store and the
// parse stack; carries out load commands and steps the parse for tokens.
// ----------------------------------------------------------------------------
module llp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              cmd_valid,
  input  llp_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output llp_pkg::status_t  st,
  output logic              res_wr,
  output llp_pkg::result_t  res,
  input  logic              rq_full
);
  import llp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START2 = 8'b0000_0010,
    S_RDTOP  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_TBL    = 8'b0001_0000,
    S_LEN    = 8'b0010_0000,
    S_RDRHS  = 8'b0100_0000,
    S_PUSH   = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic               running, running_next;
  logic [SP_W-1:0]    sp, sp_next;
  logic [CLR_W-1:0]   clr_cnt;
  logic               clearing;
  logic [EXP_W-1:0]   exp_cnt, exp_next;
  logic [5:0]         cnt, cnt_next;
  logic [4:0]         tok, tok_next;
  logic [5:0]         prod, prod_next;
  logic [4:0]         end_marker;
  logic [CNT_W-1:0]   term_count;
  logic [CNT_W-1:0]   nont_count;

  // Memories and their registered read data
  logic [5:0]         stack_mem [STACK_DEPTH];
  logic [6:0]         tbl_mem   [TBL_DEPTH];
  logic [5:0]         rhs_mem   [RHS_DEPTH];
  logic [4:0]         len_mem   [PRODUCTIONS];
  logic [5:0]         stack_q;
  logic [6:0]         tbl_q;
  logic [5:0]         rhs_q;
  logic [4:0]         len_q;

  logic               stk_we;
  logic [STK_AW-1:0]  stk_wa;
  logic [5:0]         stk_wd;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [6:0]         tbl_wd;
  logic               rhs_we;
  logic [RHS_AW-1:0]  rhs_wa;
  logic               len_we;
  logic [4:0]         len_wd;

  logic [STK_AW-1:0]  stk_ra;
  logic [TBL_AW-1:0]  tbl_ra;
  logic [RHS_AW-1:0]  rhs_ra;
  logic [PROD_AW-1:0] len_ra;
  logic [4:0]         top_idx;
  logic [OVF_W-1:0]   new_depth;

  assign clearing = (clr_cnt < CLR_W'(TBL_DEPTH));
  assign st       = '{clearing: clearing, running: running, sp: sp};
  assign top_idx  = stack_q[4:0];

  // Read addresses follow registers only, so a stall holds the read data
  assign stk_ra    = STK_AW'(sp - SP_W'(1));
  assign tbl_ra    = TBL_AW'(32'(top_idx) * TERMINALS + 32'(tok));
  assign len_ra    = tbl_q[PROD_AW-1:0];
  assign rhs_ra    = RHS_AW'(32'(prod) * RHS_MAX + 32'(cnt) - 32'd1);
  assign new_depth = OVF_W'(sp) - OVF_W'(1) + OVF_W'(len_q);

  always_ff @(posedge clk) begin
    stack_q <= stack_mem[stk_ra];
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
  end

  always_ff @(posedge clk) begin
    tbl_q <= tbl_mem[tbl_ra];
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    rhs_q <= rhs_mem[rhs_ra];
    if (rhs_we) rhs_mem[rhs_wa] <= cmd.f.rhs_symbol;
  end

  always_ff @(posedge clk) begin
    len_q <= len_mem[len_ra];
    if (len_we) len_mem[cmd.f.production[PROD_AW-1:0]] <= len_wd;
  end

  // Sequencer
  always_comb begin
    state_next   = state;
    running_next = running;
    sp_next      = sp;
    exp_next     = exp_cnt;
    cnt_next     = cnt;
    tok_next     = tok;
    prod_next    = prod;
    cmd_pop      = 1'b0;
    stk_we       = 1'b0;
    stk_wa       = stk_ra;
    stk_wd       = rhs_q;
    tbl_we       = 1'b0;
    tbl_wa       = TBL_AW'(32'(cmd.f.row_nonterminal) * TERMINALS + 32'(cmd.f.token));
    tbl_wd       = '0;
    rhs_we       = 1'b0;
    rhs_wa       = RHS_AW'(32'(cmd.f.production) * RHS_MAX + 32'(cmd.f.position));
    len_we       = 1'b0;
    len_wd       = (6'(cmd.f.rhs_length) > 6'(RHS_MAX)) ? 5'(RHS_MAX) : cmd.f.rhs_length;
    res_wr       = 1'b0;
    res          = '{action: ACT_ERROR, stack_symbol: stack_q, used_production: 6'd0,
                     error_code: ERR_NONE, last: 1'b1};

    // Sweep the prediction table after reset
    if (clearing) begin
      tbl_we = 1'b1;
      tbl_wa = clr_cnt[TBL_AW-1:0];
    end

    case (state)
      S_IDLE: begin
        if (!clearing && cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_START: begin
              stk_we     = 1'b1;
              stk_wa     = '0;
              stk_wd     = {1'b0, end_marker};
              state_next = S_START2;
            end
            OP_TABLE: begin
              if (32'(cmd.f.row_nonterminal) < NONTERMINALS &&
                  32'(cmd.f.token) < TERMINALS) begin
                if (!cmd.f.entry_valid) begin
                  tbl_we = 1'b1;
                end else if (32'(cmd.f.production) < PRODUCTIONS) begin
                  tbl_we = 1'b1;
                  tbl_wd = {1'b1, cmd.f.production};
                end
              end
            end
            OP_SYM: begin
              rhs_we = (32'(cmd.f.production) < PRODUCTIONS) &&
                       (32'(cmd.f.position) < RHS_MAX);
            end
            OP_LEN: begin
              len_we = (32'(cmd.f.production) < PRODUCTIONS);
            end
            OP_TOKEN: begin
              if (running) begin
                tok_next   = cmd.f.token;
                exp_next   = '0;
                state_next = S_RDTOP;
              end
            end
            default: ;
          endcase
        end
      end

      S_START2: begin
        stk_we       = 1'b1;
        stk_wa       = STK_AW'(1);
        stk_wd       = 6'h20;
        sp_next      = SP_W'(2);
        running_next = 1'b1;
        state_next   = S_IDLE;
      end

      S_RDTOP: begin
        if (sp == '0) begin
          if (!rq_full) begin
            res_wr       = 1'b1;
            res.stack_symbol = 6'd0;
            res.error_code   = ERR_EMPTY;
            running_next = 1'b0;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!rq_full) begin
          if (!stack_q[5] && top_idx == tok) begin
            // Terminal on top equals the token
            res_wr = 1'b1;
            if (tok == end_marker) begin
              res.action   = ACT_ACCEPT;
              running_next = 1'b0;
            end else begin
              res.action = ACT_MATCH;
              sp_next    = sp - SP_W'(1);
            end
            state_next = S_IDLE;
          end else if (!stack_q[5]) begin
            res_wr         = 1'b1;
            res.error_code = (CNT_W'(top_idx) < term_count) ? ERR_MISMATCH : ERR_BAD_SYM;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else if (CNT_W'(top_idx) >= nont_count) begin
            res_wr         = 1'b1;
            res.error_code = ERR_BAD_SYM;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else if (CNT_W'(tok) >= term_count) begin
            res_wr         = 1'b1;
            res.error_code = ERR_BAD_TOK;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else begin
            state_next = S_TBL;
          end
        end
      end

      S_TBL: begin
        prod_next = tbl_q[5:0];
        if (!rq_full) begin
          if (!tbl_q[6] || 32'(tbl_q[5:0]) >= PRODUCTIONS) begin
            res_wr         = 1'b1;
            res.error_code = ERR_NO_RULE;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else if (32'(exp_cnt) >= EXPANSION_LIMIT) begin
            res_wr         = 1'b1;
            res.error_code = ERR_LIMIT;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else begin
            state_next = S_LEN;
          end
        end
      end

      S_LEN: begin
        if (!rq_full) begin
          res_wr = 1'b1;
          if (32'(new_depth) > STACK_DEPTH) begin
            res.error_code = ERR_OVERFLOW;
            running_next   = 1'b0;
            state_next     = S_IDLE;
          end else begin
            res.action          = ACT_EXPAND;
            res.used_production = prod;
            res.last            = 1'b0;
            sp_next             = sp - SP_W'(1);
            exp_next            = exp_cnt + EXP_W'(1);
            cnt_next            = 6'(len_q);
            state_next          = (len_q != 5'd0) ? S_RDRHS : S_RDTOP;
          end
        end
      end

      S_RDRHS: begin
        state_next = S_PUSH;
      end

      S_PUSH: begin
        // Push symbols last to first so the first lands on top
        stk_we     = 1'b1;
        stk_wa     = STK_AW'(sp);
        sp_next    = sp + SP_W'(1);
        cnt_next   = cnt - 6'd1;
        state_next = (cnt != 6'd1) ? S_RDRHS : S_RDTOP;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tok     <= tok_next;
    prod    <= prod_next;
    cnt     <= cnt_next;
    exp_cnt <= exp_next;
  end

  // Control state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running    <= 1'b0;
      sp         <= '0;
      clr_cnt    <= '0;
      end_marker <= 5'd0;
      term_count <= CNT_W'(TERMINALS < 32 ? TERMINALS : 32);
      nont_count <= CNT_W'(NONTERMINALS < 32 ? NONTERMINALS : 32);
    end else begin
      state   <= state_next;
      running <= running_next;
      sp      <= sp_next;
      if (clearing) clr_cnt <= clr_cnt + CLR_W'(1);
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_MARKER: end_marker <= cfg_data[4:0];
          CFG_TERM_COUNT: term_count <= (32'(cfg_data) > TERMINALS) ?
                                        CNT_W'(TERMINALS) : CNT_W'(cfg_data);
          CFG_NONT_COUNT: nont_count <= (32'(cfg_data) > NONTERMINALS) ?
                                        CNT_W'(NONTERMINALS) : CNT_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/ll1_predictive_parse_engine.sv
// ----------------------------------------------------------------------------
// ll1_predictive_parse_engine: table-driven LL(1) parse engine
// Intake queue, parse sequencer with table, production store and stack,
// and a result queue.
// ----------------------------------------------------------------------------
// After reset the engine sweeps its 1024-entry prediction table and holds
// full high meanwhile. A beat is registered in the intake queue before the
// sequencer takes it; load items are then carried out as they are taken,
// and a start also passes through S_START2. For a token the sequencer
// takes it, tests the stack top in S_RDTOP and S_DECIDE, expands through
// S_TBL and S_LEN and pushes each symbol through S_RDRHS and S_PUSH; the
// steps follow from the stack, table and production memories, read in turn
// by one sequencer. Results wait in a four-beat queue, and a full queue
// stalls the sequencer.
module ll1_predictive_parse_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  llp_pkg::item_t    item,
  output logic              empty,
  input  logic              pop,
  output llp_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data
);
  import llp_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  status_t st;
  logic    res_wr;
  result_t res;
  logic    rq_full;

  llp_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item), .st(st),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  llp_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .st(st), .res_wr(res_wr), .res(res), .rq_full(rq_full)
  );

  llp_rq u_rq (
    .clk(clk), .rst(rst), .wr(res_wr), .wdata(res), .rq_full(rq_full),
    .empty(empty), .pop(pop), .result(result)
  );

  // Stack never grows past its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(st.sp) <= STACK_DEPTH) else $error("stack pointer beyond depth");

  // No intake during the table sweep
  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    st.clearing |-> full) else $error("intake open during table sweep");

  // No results can exist while the table is still being swept
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    st.clearing |-> empty) else $error("result during table sweep");

endmodule

FILE: tb/sv/llp_parse_checker.sv
// ----------------------------------------------------------------------------
// llp_parse_checker: result predictor and scoreboard of the LL(1) parse engine
// Watches the item, result and configuration ports, keeps its own copy of
// the table, production store, stack and registers, and checks every result
// beat against the oldest predicted step.
// ----------------------------------------------------------------------------
module llp_parse_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  llp_pkg::item_t   item,
  input  logic             empty,
  input  logic             pop,
  input  llp_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [5:0]       cfg_data,
  output int               fail_count,
  output int               pending
);
  import llp_pkg::*;

  // Mirror of the engine state
  logic [5:0] stack_mem [STACK_DEPTH];
  int         stack_top;
  logic [6:0] rule_table [TBL_DEPTH];
  logic [5:0] rhs_syms [RHS_DEPTH];
  logic [4:0] rhs_lens [PRODUCTIONS];
  bit         parsing;
  logic [4:0] end_mark;
  int         term_limit;
  int         nont_limit;

  result_t steps_due[$];
  int      bad_beats = 0;

  function automatic int clamp_count(input logic [5:0] v, input int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  task automatic log_step(input logic [1:0] act, input logic [5:0] sym,
                          input logic [5:0] prod, input logic [2:0] err,
                          input logic fin);
    result_t r;
    r.action          = act;
    r.stack_symbol    = sym;
    r.used_production = prod;
    r.error_code      = err;
    r.last            = fin;
    steps_due.push_back(r);
  endtask

  // Drive the parse with one token until it is matched, accepted or fails
  task automatic parse_token(input logic [4:0] tok);
    int         nexp;
    int         prod;
    int         len;
    bit         done;
    logic [5:0] x;
    logic [6:0] ent;
    logic [2:0] err;
    nexp = 0;
    done = 0;
    while (!done) begin
      if (stack_top == 0) begin
        log_step(ACT_ERROR, 6'd0, 6'd0, ERR_EMPTY, 1'b1);
        parsing = 0;
        done = 1;
      end else begin
        x = stack_mem[stack_top - 1];
        err = ERR_NONE;
        if (!x[5] && x[4:0] == tok) begin
          if (tok == end_mark) begin
            log_step(ACT_ACCEPT, x, 6'd0, ERR_NONE, 1'b1);
            parsing = 0;
          end else begin
            stack_top--;
            log_step(ACT_MATCH, x, 6'd0, ERR_NONE, 1'b1);
          end
          done = 1;
        end else if (!x[5]) begin
          err = (x[4:0] < term_limit) ? ERR_MISMATCH : ERR_BAD_SYM;
        end else if (x[4:0] >= nont_limit) begin
          err = ERR_BAD_SYM;
        end else if (tok >= term_limit) begin
          err = ERR_BAD_TOK;
        end else begin
          ent = rule_table[{x[4:0], tok}];
          if (!ent[6]) begin
            err = ERR_NO_RULE;
          end else if (nexp >= EXPANSION_LIMIT) begin
            err = ERR_LIMIT;
          end else begin
            prod = ent[5:0];
            len  = rhs_lens[prod];
            if (stack_top - 1 + len > STACK_DEPTH) begin
              err = ERR_OVERFLOW;
            end else begin
              // replace the nonterminal by its right-hand side, leftmost on top
              stack_top--;
              for (int i = len; i > 0; i--) begin
                stack_mem[stack_top] = rhs_syms[prod * RHS_MAX + i - 1];
                stack_top++;
              end
              nexp++;
              log_step(ACT_EXPAND, x, ent[5:0], ERR_NONE, 1'b0);
            end
          end
        end
        if (!done && err != ERR_NONE) begin
          log_step(ACT_ERROR, x, 6'd0, err, 1'b1);
          parsing = 0;
          done = 1;
        end
      end
    end
  endtask

  task automatic predict_item(input item_t it);
    case (it.kind)
      KIND_START: begin
        stack_mem[0] = {1'b0, end_mark};
        stack_mem[1] = 6'h20;
        stack_top = 2;
        parsing = 1;
      end
      KIND_TABLE: begin
        if (!it.entry_valid)
          rule_table[{it.row_nonterminal, it.token}] = 7'd0;
        else
          rule_table[{it.row_nonterminal, it.token}] = {1'b1, it.production};
      end
      KIND_SYM: rhs_syms[{it.production, it.position}] = it.rhs_symbol;
      KIND_LEN: rhs_lens[it.production] = (it.rhs_length > RHS_MAX) ? RHS_MAX
                                                                    : it.rhs_length;
      KIND_TOKEN: if (parsing) parse_token(it.token);
      default: ;
    endcase
  endtask

  task automatic check_beat(input result_t got);
    result_t want;
    if (steps_due.size() == 0) begin
      if (bad_beats < 10)
        $display("unexpected result: action %0d sym %0h prod %0d err %0d last %0d",
                 got.action, got.stack_symbol, got.used_production,
                 got.error_code, got.last);
      bad_beats++;
    end else begin
      want = steps_due.pop_front();
      if (got.action !== want.action || got.stack_symbol !== want.stack_symbol ||
          got.used_production !== want.used_production ||
          got.error_code !== want.error_code || got.last !== want.last) begin
        if (bad_beats < 10)
          $display("mismatch: exp act %0d sym %0h prod %0d err %0d last %0d / got act %0d sym %0h prod %0d err %0d last %0d",
                   want.action, want.stack_symbol, want.used_production,
                   want.error_code, want.last, got.action, got.stack_symbol,
                   got.used_production, got.error_code, got.last);
        bad_beats++;
      end
    end
  endtask

  // Check the popped beat first, then predict what the accepted item causes
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TBL_DEPTH; i++) rule_table[i] = 7'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_mem[i] = 6'd0;
      stack_top  = 0;
      parsing    = 0;
      end_mark   = 5'd0;
      term_limit = TERMINALS;
      nont_limit = NONTERMINALS;
      steps_due.delete();
    end else begin
      if (pop && !empty) check_beat(result);
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_MARKER: end_mark = cfg_data[4:0];
          CFG_TERM_COUNT: term_limit = clamp_count(cfg_data, TERMINALS);
          CFG_NONT_COUNT: nont_limit = clamp_count(cfg_data, NONTERMINALS);
          default: ;
        endcase
      end
      if (push && !full) predict_item(item);
    end
    fail_count <= bad_beats;
    pending    <= steps_due.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LL(1) parse engine
// Loads an expression grammar plus a looping rule, runs directed parses for
// every action and each error but bad token and bad symbol, then random
// sentences under several register settings, random gaps and stalls each side.
// ----------------------------------------------------------------------------
module testbench;
  import llp_pkg::*;

  // Terminals of the expression grammar
  localparam logic [4:0] T_ID   = 5'd1;
  localparam logic [4:0] T_PLUS = 5'd2;
  localparam logic [4:0] T_STAR = 5'd3;
  localparam logic [4:0] T_LP   = 5'd4;
  localparam logic [4:0] T_RP   = 5'd5;
  localparam logic [4:0] T_HOLE = 5'd6;
  localparam logic [4:0] T_LOOP = 5'd7;

  // Nonterminals
  localparam logic [4:0] N_E    = 5'd0;
  localparam logic [4:0] N_EP   = 5'd1;
  localparam logic [4:0] N_T    = 5'd2;
  localparam logic [4:0] N_TP   = 5'd3;
  localparam logic [4:0] N_F    = 5'd4;
  localparam logic [4:0] N_LOOP = 5'd6;

  // Productions
  localparam logic [5:0] P_E      = 6'd0;
  localparam logic [5:0] P_EP_ADD = 6'd1;
  localparam logic [5:0] P_EP_EPS = 6'd2;
  localparam logic [5:0] P_T      = 6'd3;
  localparam logic [5:0] P_TP_MUL = 6'd4;
  localparam logic [5:0] P_TP_EPS = 6'd5;
  localparam logic [5:0] P_F_PAR  = 6'd6;
  localparam logic [5:0] P_F_ID   = 6'd7;
  localparam logic [5:0] P_TO_LP  = 6'd10;
  localparam logic [5:0] P_LOOP   = 6'd11;

  logic       clk = 0;
  logic       rst = 1;
  logic       push = 0;
  logic       full;
  item_t      item = '0;
  logic       empty;
  logic       pop = 0;
  result_t    result;
  logic       cfg_we = 0;
  logic [1:0] cfg_index = CFG_END_MARKER;
  logic [5:0] cfg_data = 6'd0;
  int         fail_count;
  int         pending;

  logic [4:0] tokens_q[$];
  int         random_tokens;
  bit         send_fast;
  bit         take_fast;

  ll1_predictive_parse_engine dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  llp_parse_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic item_t noisy_item(input logic [2:0] kind);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.kind = kind;
    return it;
  endfunction

  // Offer one beat after a random gap; push stays high until lowered
  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_token(input logic [4:0] tok);
    item_t it;
    it = noisy_item(KIND_TOKEN);
    it.token = tok;
    send_item(it);
  endtask

  task automatic set_rule(input logic [4:0] row, input logic [4:0] tok,
                          input logic [5:0] prod, input bit valid);
    item_t it;
    it = noisy_item(KIND_TABLE);
    it.row_nonterminal = row;
    it.token = tok;
    it.production = prod;
    it.entry_valid = valid;
    send_item(it);
  endtask

  task automatic set_rhs(input logic [5:0] prod, input int len,
                         input logic [5:0] s0, input logic [5:0] s1,
                         input logic [5:0] s2);
    item_t       it;
    logic [5:0]  syms[3];
    syms = '{s0, s1, s2};
    for (int i = 0; i < len; i++) begin
      it = noisy_item(KIND_SYM);
      it.production = prod;
      it.position = i[3:0];
      it.rhs_symbol = syms[i];
      send_item(it);
    end
    it = noisy_item(KIND_LEN);
    it.production = prod;
    it.rhs_length = len[4:0];
    send_item(it);
  endtask

  // Hold the input and let the engine drain before touching registers
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [5:0] endm, input logic [5:0] tcnt,
                          input logic [5:0] ncnt);
    wait_drained();
    write_cfg(CFG_END_MARKER, endm);
    write_cfg(CFG_TERM_COUNT, tcnt);
    write_cfg(CFG_NONT_COUNT, ncnt);
    cfg_we <= 1'b0;
  endtask

  task automatic load_end_column(input logic [4:0] endm);
    set_rule(N_EP, endm, P_EP_EPS, 1'b1);
    set_rule(N_TP, endm, P_TP_EPS, 1'b1);
  endtask

  task automatic load_grammar();
    set_rhs(P_E, 2, {1'b1, N_T}, {1'b1, N_EP}, 6'd0);
    set_rhs(P_EP_ADD, 3, {1'b0, T_PLUS}, {1'b1, N_T}, {1'b1, N_EP});
    set_rhs(P_EP_EPS, 0, 6'd0, 6'd0, 6'd0);
    set_rhs(P_T, 2, {1'b1, N_F}, {1'b1, N_TP}, 6'd0);
    set_rhs(P_TP_MUL, 3, {1'b0, T_STAR}, {1'b1, N_F}, {1'b1, N_TP});
    set_rhs(P_TP_EPS, 0, 6'd0, 6'd0, 6'd0);
    set_rhs(P_F_PAR, 3, {1'b0, T_LP}, {1'b1, N_E}, {1'b0, T_RP});
    set_rhs(P_F_ID, 1, {1'b0, T_ID}, 6'd0, 6'd0);
    set_rhs(P_TO_LP, 1, {1'b1, N_LOOP}, 6'd0, 6'd0);
    set_rhs(P_LOOP, 1, {1'b1, N_LOOP}, 6'd0, 6'd0);
    set_rule(N_E, T_ID, P_E, 1'b1);
    set_rule(N_E, T_LP, P_E, 1'b1);
    set_rule(N_E, T_LOOP, P_TO_LP, 1'b1);
    set_rule(N_EP, T_PLUS, P_EP_ADD, 1'b1);
    set_rule(N_EP, T_RP, P_EP_EPS, 1'b1);
    set_rule(N_T, T_ID, P_T, 1'b1);
    set_rule(N_T, T_LP, P_T, 1'b1);
    set_rule(N_TP, T_STAR, P_TP_MUL, 1'b1);
    set_rule(N_TP, T_PLUS, P_TP_EPS, 1'b1);
    set_rule(N_TP, T_RP, P_TP_EPS, 1'b1);
    set_rule(N_F, T_LP, P_F_PAR, 1'b1);
    set_rule(N_F, T_ID, P_F_ID, 1'b1);
    set_rule(N_LOOP, T_LOOP, P_LOOP, 1'b1);
  endtask

  // Random well-formed expression into tokens_q
  task automatic build_factor(input int depth);
    if (depth > 0 && $urandom_range(0, 3) == 0) begin
      tokens_q.push_back(T_LP);
      build_expr(depth - 1);
      tokens_q.push_back(T_RP);
    end else begin
      tokens_q.push_back(T_ID);
    end
  endtask

  task automatic build_term(input int depth);
    build_factor(depth);
    while ($urandom_range(0, 2) == 0) begin
      tokens_q.push_back(T_STAR);
      build_factor(depth);
    end
  endtask

  task automatic build_expr(input int depth);
    build_term(depth);
    while ($urandom_range(0, 2) == 0) begin
      tokens_q.push_back(T_PLUS);
      build_term(depth);
    end
  endtask

  task automatic run_parse();
    send_item(noisy_item(KIND_START));
    foreach (tokens_q[i]) send_token(tokens_q[i]);
    random_tokens += tokens_q.size();
  endtask

  // Loads and odd kinds aimed away from the grammar's rows and productions
  task automatic send_noise();
    item_t it;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: it = noisy_item(3'($urandom_range(5, 7)));
        1: begin
          it = noisy_item(KIND_TABLE);
          it.row_nonterminal = 5'($urandom_range(8, 31));
        end
        2: begin
          it = noisy_item(KIND_SYM);
          it.production = 6'($urandom_range(16, 63));
        end
        default: begin
          it = noisy_item(KIND_LEN);
          it.production = 6'($urandom_range(16, 63));
        end
      endcase
      send_item(it);
    end
    send_token(5'($urandom_range(0, 31)));
  endtask

  task automatic random_sentence(input logic [4:0] endm);
    int flavor;
    int cut;
    tokens_q.delete();
    flavor = $urandom_range(0, 19);
    if (flavor == 0) begin
      repeat (12) tokens_q.push_back(T_LP);
      run_parse();
    end else if (flavor == 1) begin
      tokens_q.push_back(T_LOOP);
      run_parse();
    end else if (flavor == 2) begin
      send_noise();
    end else begin
      build_expr(3);
      tokens_q.push_back(endm);
      if ($urandom_range(0, 4) == 0)
        tokens_q[$urandom_range(0, tokens_q.size() - 1)] = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, tokens_q.size());
        repeat (cut) void'(tokens_q.pop_back());
      end
      run_parse();
    end
  endtask

  // Result side: random stalls and one long hold-off to back up the engine
  initial begin
    int gap;
    int beats;
    beats = 0;
    take_fast = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) take_fast = !take_fast;
      gap = take_fast ? 0 : $urandom_range(0, 8);
      if (beats == 30) gap = 400;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      beats++;
    end
  end

  initial begin
    logic [5:0] ends [6];
    logic [5:0] tcnts [6];
    logic [5:0] ncnts [6];
    ends  = '{6'd0, 6'd31, 6'd20, 6'd0, 6'd31, 6'd0};
    tcnts = '{6'd32, 6'd63, 6'd8, 6'd32, 6'd1, 6'd0};
    ncnts = '{6'd32, 6'd32, 6'd7, 6'd5, 6'd1, 6'd0};
    send_fast = 0;
    random_tokens = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_regs(6'd0, 6'd32, 6'd32);
    write_cfg(2'd3, 6'd63);
    cfg_we <= 1'b0;
    load_grammar();
    load_end_column(5'd0);

    // directed parses: accept, nested accept, mismatch, no rule, limit, overflow
    tokens_q = '{T_ID, 5'd0};
    run_parse();
    tokens_q = '{T_LP, T_ID, T_PLUS, T_ID, T_RP, T_STAR, T_ID, 5'd0};
    run_parse();
    tokens_q = '{T_LP, T_ID, 5'd0};
    run_parse();
    set_rule(N_E, T_HOLE, P_E, 1'b1);
    set_rule(N_E, T_HOLE, P_E, 1'b0);
    tokens_q = '{T_HOLE};
    run_parse();
    send_token(T_ID);
    tokens_q = '{T_LOOP};
    run_parse();
    tokens_q = '{};
    repeat (12) tokens_q.push_back(T_LP);
    run_parse();
    send_item(noisy_item(3'd5));
    send_item(noisy_item(3'd6));
    send_item(noisy_item(3'd7));

    // drop the bottom marker by moving the end marker mid-parse, then underflow
    tokens_q = '{T_ID};
    run_parse();
    set_regs(6'd31, 6'd32, 6'd32);
    send_token(5'd0);
    send_token(T_ID);

    for (int ph = 0; ph < 6 || random_tokens < 150; ph++) begin
      set_regs(ends[ph % 6], tcnts[ph % 6], ncnts[ph % 6]);
      load_end_column(ends[ph % 6][4:0]);
      repeat (3) random_sentence(ends[ph % 6][4:0]);
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/llp_pkg.sv
rtl/core/llp_front.sv
rtl/core/llp_rq.sv
rtl/core/llp_back.sv
rtl/core/ll1_predictive_parse_engine.sv
tb/sv/llp_parse_checker.sv
tb/sv/testbench.sv
